/* hdl/bfha_pkg.sv */
// Shared types and constants for the best-fit hole allocator.
package bfha_pkg;

   localparam int HOLE_SLOTS = 64;
   localparam int IDX_W      = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
   localparam int ADDR_W     = 32;
   localparam int PID_W      = 16;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_ALLOC = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_NOFIT   = 2'd1,
      STS_ZEROPID = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic              vld;
      logic              hit;
      logic [ADDR_W-1:0] len;
      logic [ADDR_W-1:0] base;
      logic [IDX_W-1:0]  idx;
   } tok_type;

   // request fields broadcast to every cell while a search runs
   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] base;
   } ctl_type;

   // write-back of the chosen slot
   typedef struct packed {
      logic              vld;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] size;
   } commit_type;

endpackage

/* hdl/bfha_cell.sv */
// One hole slot of the allocator chain with its search token stage.
module bfha_cell
   import bfha_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  ctl_type          ctl,
   input  commit_type       commit,
   input  tok_type          tok_prev,
   output tok_type          tok_next
);

   logic              valid_ff, valid_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   tok_type           tok_ff, tok_in;
   logic              fits;
   logic              better;

   assign fits   = valid_ff && (len_ff >= ctl.size);
   assign better = !tok_prev.hit || (len_ff < tok_prev.len) ||
                   ((len_ff == tok_prev.len) && (base_ff < tok_prev.base));

   always_comb begin
      valid_in = valid_ff;
      base_in  = base_ff;
      len_in   = len_ff;
      tok_in   = tok_prev;
      if (tok_prev.vld) begin
         case (ctl.op)
            OP_ADD: begin
               if (!tok_prev.hit && !valid_ff) begin
                  valid_in   = 1'b1;
                  base_in    = ctl.base;
                  len_in     = ctl.size;
                  tok_in.hit = 1'b1;
               end
            end
            OP_ALLOC: begin
               if (fits && better) begin
                  tok_in.hit  = 1'b1;
                  tok_in.len  = len_ff;
                  tok_in.base = base_ff;
                  tok_in.idx  = cell_idx;
               end
            end
            default: begin
               tok_in = tok_prev;
            end
         endcase
      end
      if (commit.vld && (commit.idx == cell_idx)) begin
         if (len_ff > commit.size) begin
            len_in  = len_ff - commit.size;
            base_in = base_ff + commit.size;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      len_ff  <= len_in;
   end

   assign tok_next = tok_ff;

endmodule

/* hdl/best_fit_hole_allocator.sv */
// Best-fit hole allocator: a chain of hole-slot cells searched by a traveling token.
// Path: the token is launched from a register, passes each cell's token register in turn, and the
// tail result is registered before the response register; a zero process id skips the chain.
// Flow: one request at a time; a new request is accepted only once the previous result has moved
// into the response register, which waits while a pending response is not taken by rsp_tready.
// Reset: synchronous, clears the slot valid bits, the token chain and the control state.
module best_fit_hole_allocator
   import bfha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // process_id[15:0] hole_base_in[47:16] request_size[79:48]
   input  logic [0:0]  req_tuser,  // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // granted_address[31:0] owner[47:32] size[79:48]
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [PID_W-1:0]  pid_ff, pid_in;
   logic [ADDR_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] hbase_ff, hbase_in;
   logic              zpid_ff, zpid_in;
   logic              launch_ff, launch_in;
   logic              res_hit_ff, res_hit_in;
   logic [ADDR_W-1:0] res_base_ff, res_base_in;
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [PID_W-1:0]  rsp_owner_ff, rsp_owner_in;
   logic [ADDR_W-1:0] rsp_size_ff, rsp_size_in;

   logic       accept;
   logic       fire;
   logic       req_zpid;
   ctl_type    ctl;
   commit_type commit;
   tok_type    tok_head;
   tok_type    tok_chain [HOLE_SLOTS+1];
   tok_type    tail;

   assign accept   = req_tvalid && req_tready;
   assign req_zpid = (op_type'(req_tuser[0]) == OP_ALLOC) && (req_tdata[15:0] == '0);
   assign fire     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign tail     = tok_chain[HOLE_SLOTS];

   assign ctl.op   = op_ff;
   assign ctl.size = size_ff;
   assign ctl.base = hbase_ff;

   always_comb begin
      tok_head     = '0;
      tok_head.vld = launch_ff;
   end

   assign tok_chain[0] = tok_head;

   for (genvar g = 0; g < HOLE_SLOTS; g++) begin : g_cell
      bfha_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_W'(g)),
         .ctl      (ctl),
         .commit   (commit),
         .tok_prev (tok_chain[g]),
         .tok_next (tok_chain[g+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_zpid ? S_DONE : S_RUN;
            end
         end
         S_RUN: begin
            if (tail.vld) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready    = (state_ff == S_IDLE);
      op_in         = op_ff;
      pid_in        = pid_ff;
      size_in       = size_ff;
      hbase_in      = hbase_ff;
      zpid_in       = zpid_ff;
      launch_in     = 1'b0;
      res_hit_in    = res_hit_ff;
      res_base_in   = res_base_ff;
      res_idx_in    = res_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_size_in   = rsp_size_ff;
      commit        = '0;

      if (accept) begin
         op_in      = op_type'(req_tuser[0]);
         pid_in     = req_tdata[15:0];
         hbase_in   = req_tdata[47:16];
         size_in    = req_tdata[79:48];
         zpid_in    = req_zpid;
         launch_in  = !req_zpid;
         res_hit_in = 1'b0;
      end

      if ((state_ff == S_RUN) && tail.vld) begin
         res_hit_in  = tail.hit;
         res_base_in = tail.base;
         res_idx_in  = tail.idx;
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = '0;
         rsp_owner_in = '0;
         rsp_size_in  = '0;
         if (op_ff == OP_ADD) begin
            rsp_status_in = res_hit_ff ? STS_OK : STS_FULL;
         end else if (zpid_ff) begin
            rsp_status_in = STS_ZEROPID;
         end else if (!res_hit_ff) begin
            rsp_status_in = STS_NOFIT;
         end else begin
            rsp_status_in = STS_OK;
            rsp_addr_in   = res_base_ff;
            rsp_owner_in  = pid_ff;
            rsp_size_in   = size_ff;
            commit.vld    = 1'b1;
            commit.idx    = res_idx_ff;
            commit.size   = size_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      size_ff       <= size_in;
      hbase_ff      <= hbase_in;
      zpid_ff       <= zpid_in;
      res_hit_ff    <= res_hit_in;
      res_base_ff   <= res_base_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_size_ff, rsp_owner_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
